// File: rtl/fpa_pkg.sv
// ---------------------------------------------------------------------------
// fpa_pkg: shared types and codes of the fixed-point operator ALU
// Operator codes, status codes, word structs and the lane control word that
// travels down the divider cell chain.
// ---------------------------------------------------------------------------
package fpa_pkg;

   // operator codes
   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_MUL  = 5'd2;
   localparam logic [4:0] OP_DIV  = 5'd3;
   localparam logic [4:0] OP_MOD  = 5'd4;
   localparam logic [4:0] OP_AND  = 5'd5;
   localparam logic [4:0] OP_OR   = 5'd6;
   localparam logic [4:0] OP_XOR  = 5'd7;
   localparam logic [4:0] OP_NOT  = 5'd8;
   localparam logic [4:0] OP_NEG  = 5'd9;
   localparam logic [4:0] OP_LNOT = 5'd10;
   localparam logic [4:0] OP_EQ   = 5'd11;
   localparam logic [4:0] OP_NE   = 5'd12;
   localparam logic [4:0] OP_LT   = 5'd13;
   localparam logic [4:0] OP_GT   = 5'd14;
   localparam logic [4:0] OP_LE   = 5'd15;
   localparam logic [4:0] OP_GE   = 5'd16;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_DIVZERO  = 2'd2;

   // how the output stage finishes a word
   typedef enum logic [1:0] {
      SEL_PASS,
      SEL_MUL,
      SEL_DIV,
      SEL_MOD
   } sel_type;

   typedef struct packed {
      logic        [4:0]  kind;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic        [1:0]  status;
   } rsp_type;

   // control word carried alongside the divider lane
   typedef struct packed {
      sel_type            sel;
      logic               neg_q;
      logic               neg_r;
      logic signed [63:0] prod;
      rsp_type            rsp;
   } ctrl_type;

endpackage

// File: rtl/fixed_point_operator_alu.sv
// ---------------------------------------------------------------------------
// fixed_point_operator_alu: numeric operators on 32-bit fixed-point words
// Entry stage, a chain of restoring-division cells and an output stage.
// ---------------------------------------------------------------------------
// Usage:
//   A request word (kind, operand_a, operand_b) is taken at each rising edge
//   where start is high; busy is always low, so one word may be issued every
//   cycle. Each response word (result, status) is shown on rsp for exactly
//   one cycle with rsp_strobe high, in issue order.
// Every operator takes the same path. The entry stage
//   registers the operand logic and the 32x32 product, then the word walks
//   through 32 + FRACTION_BITS division cells (one quotient bit per cell),
//   then the output stage applies signs, the product shift and range checks.
// Throughput: one word per cycle; the cells form a pipeline.
// Reset (synchronous, active high) drops every word in flight; nothing is
//   cleared in the datapath. The receiver cannot stall: each response is
//   gone after its cycle.
// ---------------------------------------------------------------------------
module fixed_point_operator_alu #(
   parameter int FRACTION_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpa_pkg::req_type req,
   output logic             rsp_strobe,
   output fpa_pkg::rsp_type rsp
);
   import fpa_pkg::*;

   localparam int QW = 32 + FRACTION_BITS;
   localparam logic [31:0] ONE = 32'(64'd1 << FRACTION_BITS);

   // entry stage combinational values
   logic signed [31:0] a, b, ia, ib;
   logic signed [32:0] sum, dif;
   logic [31:0]        mag_a, mag_b;
   ctrl_type           ctrl_in;
   logic [QW-1:0]      dq_in;

   always_comb begin
      a     = req.operand_a;
      b     = req.operand_b;
      ia    = a >>> FRACTION_BITS;
      ib    = b >>> FRACTION_BITS;
      sum   = {a[31], a} + {b[31], b};
      dif   = {a[31], a} - {b[31], b};
      mag_a = a[31] ? 32'(-a) : a;
      mag_b = b[31] ? 32'(-b) : b;
      dq_in = (req.kind == OP_MOD) ? QW'(mag_a) : {mag_a, {FRACTION_BITS{1'b0}}};
      ctrl_in.sel        = SEL_PASS;
      ctrl_in.neg_q      = a[31] ^ b[31];
      ctrl_in.neg_r      = a[31];
      ctrl_in.prod       = 64'(a) * 64'(b);
      ctrl_in.rsp.result = '0;
      ctrl_in.rsp.status = ST_OK;
      unique case (req.kind)
         OP_ADD: begin
            if (sum[32] != sum[31]) ctrl_in.rsp.status = ST_OVERFLOW;
            else                    ctrl_in.rsp.result = sum[31:0];
         end
         OP_SUB: begin
            if (dif[32] != dif[31]) ctrl_in.rsp.status = ST_OVERFLOW;
            else                    ctrl_in.rsp.result = dif[31:0];
         end
         OP_MUL: ctrl_in.sel = SEL_MUL;
         OP_DIV, OP_MOD: begin
            if (b == 0)                    ctrl_in.rsp.status = ST_DIVZERO;
            else if (req.kind == OP_DIV)   ctrl_in.sel = SEL_DIV;
            else                           ctrl_in.sel = SEL_MOD;
         end
         OP_AND:  ctrl_in.rsp.result = (ia & ib) << FRACTION_BITS;
         OP_OR:   ctrl_in.rsp.result = (ia | ib) << FRACTION_BITS;
         OP_XOR:  ctrl_in.rsp.result = (ia ^ ib) << FRACTION_BITS;
         OP_NOT:  ctrl_in.rsp.result = (~ia) << FRACTION_BITS;
         OP_NEG:  ctrl_in.rsp.result = 32'(-a);
         OP_LNOT: ctrl_in.rsp.result = (a == 0) ? ONE : '0;
         OP_EQ:   ctrl_in.rsp.result = (a == b) ? ONE : '0;
         OP_NE:   ctrl_in.rsp.result = (a != b) ? ONE : '0;
         OP_LT:   ctrl_in.rsp.result = (a < b)  ? ONE : '0;
         OP_GT:   ctrl_in.rsp.result = (a > b)  ? ONE : '0;
         OP_LE:   ctrl_in.rsp.result = (a <= b) ? ONE : '0;
         OP_GE:   ctrl_in.rsp.result = (a >= b) ? ONE : '0;
         default: ctrl_in.rsp.result = '0;
      endcase
   end

   // entry stage registers
   logic          entry_valid_ff;
   ctrl_type      entry_ctrl_ff;
   logic [QW-1:0] entry_dq_ff;
   logic [31:0]   entry_dvs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= start;
      end
      entry_ctrl_ff <= ctrl_in;
      entry_dq_ff   <= dq_in;
      entry_dvs_ff  <= mag_b;
   end

   // division cell chain
   logic          valid_c [QW+1];
   ctrl_type      ctrl_c  [QW+1];
   logic [QW-1:0] dq_c    [QW+1];
   logic [31:0]   rem_c   [QW+1];
   logic [31:0]   dvs_c   [QW+1];

   assign valid_c[0] = entry_valid_ff;
   assign ctrl_c[0]  = entry_ctrl_ff;
   assign dq_c[0]    = entry_dq_ff;
   assign rem_c[0]   = '0;
   assign dvs_c[0]   = entry_dvs_ff;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fpa_cell #(.QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_c[i]),
         .ctrl_in   (ctrl_c[i]),
         .dq_in     (dq_c[i]),
         .rem_in    (rem_c[i]),
         .dvs_in    (dvs_c[i]),
         .valid_out (valid_c[i+1]),
         .ctrl_out  (ctrl_c[i+1]),
         .dq_out    (dq_c[i+1]),
         .rem_out   (rem_c[i+1]),
         .dvs_out   (dvs_c[i+1])
      );
   end

   // output stage: signs, product shift, range checks
   ctrl_type           last;
   logic [63:0]        q64;
   logic signed [63:0] mw;
   rsp_type            rsp_in;
   logic               strobe_ff;
   rsp_type            rsp_ff;

   always_comb begin
      last   = ctrl_c[QW];
      q64    = 64'(dq_c[QW]);
      mw     = last.prod >>> FRACTION_BITS;
      rsp_in = last.rsp;
      unique case (last.sel)
         SEL_PASS: rsp_in = last.rsp;
         SEL_MUL: begin
            if (mw[63:31] != {33{mw[31]}}) rsp_in = '{result: '0, status: ST_OVERFLOW};
            else                           rsp_in = '{result: mw[31:0], status: ST_OK};
         end
         SEL_DIV: begin
            if (!last.neg_q) begin
               if (q64[63:31] != '0) rsp_in = '{result: '0, status: ST_OVERFLOW};
               else                  rsp_in = '{result: q64[31:0], status: ST_OK};
            end else begin
               if (q64[63:32] != '0 || (q64[31] && q64[30:0] != '0))
                  rsp_in = '{result: '0, status: ST_OVERFLOW};
               else
                  rsp_in = '{result: 32'(-q64[31:0]), status: ST_OK};
            end
         end
         SEL_MOD: rsp_in = '{result: last.neg_r ? 32'(-rem_c[QW]) : rem_c[QW],
                             status: ST_OK};
         default: rsp_in = last.rsp;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_c[QW];
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
endmodule

// File: rtl/fpa_cell.sv
// ---------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// where it fits and shifts the quotient bit in; registers everything.
// ---------------------------------------------------------------------------
module fpa_cell #(
   parameter int QW = 44
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  fpa_pkg::ctrl_type ctrl_in,
   input  logic [QW-1:0]     dq_in,
   input  logic [31:0]       rem_in,
   input  logic [31:0]       dvs_in,
   output logic              valid_out,
   output fpa_pkg::ctrl_type ctrl_out,
   output logic [QW-1:0]     dq_out,
   output logic [31:0]       rem_out,
   output logic [31:0]       dvs_out
);
   import fpa_pkg::*;

   logic          valid_ff;
   ctrl_type      ctrl_ff;
   logic [QW-1:0] dq_ff, dq_in_w;
   logic [31:0]   rem_ff, rem_in_w, dvs_ff;
   logic [32:0]   shifted, diff;
   logic          fits;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      shifted  = {rem_in, dq_in[QW-1]};
      diff     = shifted - {1'b0, dvs_in};
      fits     = shifted >= {1'b0, dvs_in};
      rem_in_w = fits ? diff[31:0] : shifted[31:0];
      dq_in_w  = {dq_in[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ctrl_ff <= ctrl_in;
      dq_ff   <= dq_in_w;
      rem_ff  <= rem_in_w;
      dvs_ff  <= dvs_in;
   end

   assign valid_out = valid_ff;
   assign ctrl_out  = ctrl_ff;
   assign dq_out    = dq_ff;
   assign rem_out   = rem_ff;
   assign dvs_out   = dvs_ff;
endmodule

// File: sim/fixed_point_operator_alu_tb.sv
// ---------------------------------------------------------------------------
// fixed_point_operator_alu_tb: self-checking bench of the fixed-point ALU
// Drives operator words with random gaps, predicts each response with a
// behavioural model of every operator and checks responses in issue order.
// ---------------------------------------------------------------------------
module fixed_point_operator_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int FRAC      = 12;
   localparam int LATENCY   = 34 + FRAC;
   localparam int RAND_OPS  = 750;
   localparam int MAX_CYCLE = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req   = '0;
   logic    rsp_strobe;
   rsp_type rsp;

   int unsigned n_errors = 0;
   int unsigned n_cycles = 0;

   // print one mismatch line and count it
   task automatic report_error(input string msg);
      n_errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // behavioural model of one operator word
   function automatic rsp_type alu_result(input req_type w);
      rsp_type             r;
      logic signed [63:0]  a, b, wide, one;
      logic signed [31:0]  ia, ib;
      logic                chk;
      r    = '0;
      chk  = 1'b0;
      wide = '0;
      a    = 64'(w.operand_a);
      b    = 64'(w.operand_b);
      ia   = w.operand_a >>> FRAC;
      ib   = w.operand_b >>> FRAC;
      one  = 64'sd1 <<< FRAC;
      case (w.kind)
         OP_ADD: begin wide = a + b; chk = 1'b1; end
         OP_SUB: begin wide = a - b; chk = 1'b1; end
         OP_MUL: begin wide = (a * b) >>> FRAC; chk = 1'b1; end
         OP_DIV: begin
            if (b == 0) r.status = ST_DIVZERO;
            else begin wide = (a <<< FRAC) / b; chk = 1'b1; end
         end
         OP_MOD: begin
            if (b == 0) r.status = ST_DIVZERO;
            else r.result = 32'(a % b);
         end
         OP_AND:  r.result = (ia & ib) << FRAC;
         OP_OR:   r.result = (ia | ib) << FRAC;
         OP_XOR:  r.result = (ia ^ ib) << FRAC;
         OP_NOT:  r.result = (~ia) << FRAC;
         OP_NEG:  r.result = 32'(-a);
         OP_LNOT: r.result = (a == 0) ? 32'(one) : '0;
         OP_EQ:   r.result = (a == b) ? 32'(one) : '0;
         OP_NE:   r.result = (a != b) ? 32'(one) : '0;
         OP_LT:   r.result = (a <  b) ? 32'(one) : '0;
         OP_GT:   r.result = (a >  b) ? 32'(one) : '0;
         OP_LE:   r.result = (a <= b) ? 32'(one) : '0;
         OP_GE:   r.result = (a >= b) ? 32'(one) : '0;
         default: r = '0;
      endcase
      if (chk) begin
         if (wide < -64'sd2147483648 || wide > 64'sd2147483647) r.status = ST_OVERFLOW;
         else r.result = 32'(wide);
      end
      return r;
   endfunction

   class alu_scoreboard;
      rsp_type     pending[$];
      int unsigned n_words;
      int unsigned n_checked;

      function void note_word(req_type w);
         pending.push_back(alu_result(w));
         n_words++;
      endfunction

      task check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected response %h", got));
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (got.result !== want.result)
            report_error($sformatf("result %h, want %h", got.result, want.result));
         if (got.status !== want.status)
            report_error($sformatf("status %0d, want %0d", got.status, want.status));
      endtask
   endclass

   alu_scoreboard sb = new();

   fixed_point_operator_alu #(.FRACTION_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

   always #10 clock = ~clock;

   // sample responses and watch the cycle limit
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (!reset && rsp_strobe) sb.check_word(rsp);
      if (n_cycles > MAX_CYCLE) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // issue one word and hold it until taken; keep start high if no gap follows
   task automatic send_word(input req_type w, input int gap);
      start <= 1'b1;
      req   <= w;
      do @(posedge clock); while (busy);
      sb.note_word(w);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         req   <= '{kind: 5'($urandom), operand_a: $urandom, operand_b: $urandom};
         repeat (gap) @(negedge clock);
      end
   endtask

   // operand biased towards edges and small fixed-point values
   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 :
                   $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sd0;
         1: return 32'(int'($urandom_range(0, 8191)) - 4096);
         2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return $urandom_range(0, 1) ? 32'sd4096 : -32'sd4096;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      req_type w;
      int      gap;
      static logic signed [31:0] edge_vals[6] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1,
                                                  32'sd4096, -32'sd4096};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every operator over edge pairs, plus special cases
      for (int k = OP_ADD; k <= OP_GE; k++) begin
         w = '{kind: 5'(k), operand_a: edge_vals[k % 6], operand_b: edge_vals[(k + 2) % 6]};
         send_word(w, 0);
      end
      send_word('{kind: OP_DIV, operand_a: 32'sd5, operand_b: 0}, 1);
      send_word('{kind: OP_MOD, operand_a: 32'sd5, operand_b: 0}, 0);
      send_word('{kind: OP_MOD, operand_a: 32'sh8000_0000, operand_b: -1}, 0);
      send_word('{kind: OP_NEG, operand_a: 32'sh8000_0000, operand_b: 0}, 2);
      send_word('{kind: 5'd31, operand_a: -1, operand_b: -1}, 0);
      send_word('{kind: OP_MUL, operand_a: 32'sh7fff_ffff, operand_b: 32'sh7fff_ffff}, 0);

      // random: mostly valid operators, a few unused codes
      for (int i = 0; i < RAND_OPS; i++) begin
         w.kind      = $urandom_range(0, 19) == 0 ? 5'($urandom_range(17, 31))
                                                  : 5'($urandom_range(0, 16));
         w.operand_a = pick_operand();
         w.operand_b = pick_operand();
         gap = (i / 100) % 2 ? 0 : $urandom_range(0, 15);
         send_word(w, gap);
      end
      start <= 1'b0;

      // drain
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Issued %0d words over all 17 operators and unused codes; %0d checked.",
               sb.n_words, sb.n_checked);
      if (n_errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule

// File: fixed_point_operator_alu.f
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fixed_point_operator_alu.sv
sim/fixed_point_operator_alu_tb.sv
